/* sv/rgbgc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgbgc_pkg
// Shared fixed-point and divider constants for the RGB gamut constrain/limit
// pipeline.
// ----------------------------------------------------------------------------
package rgbgc_pkg;

    // Fixed-point format of every channel.
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;

    // Pipelined divider: 64-bit dividend, 32-bit divisor and quotient,
    // one quotient bit per stage.
    localparam int QUO_W   = 32;
    localparam int NUM_W   = 2 * QUO_W;
    localparam int DIV_LAT = QUO_W;

    localparam logic signed [DATA_W-1:0] ONE_Q   = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

endpackage : rgbgc_pkg
`default_nettype wire

/* sv/rgbgc_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgbgc_div
// Pipelined restoring divider, one quotient bit per stage. Flags a quotient
// that does not fit in QUO_W bits.
// ----------------------------------------------------------------------------
module rgbgc_div import rgbgc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [QUO_W-1:0] i_den,
    output logic                  o_valid,
    output logic      [QUO_W-1:0] o_quo,
    output logic                  o_ovf
);

    logic             r_vld [DIV_LAT];
    logic             r_ovf [DIV_LAT];
    logic [QUO_W-1:0] r_rem [DIV_LAT];
    logic [QUO_W-1:0] r_lo  [DIV_LAT];
    logic [QUO_W-1:0] r_quo [DIV_LAT];
    logic [QUO_W-1:0] r_den [DIV_LAT];

    for (genvar s = 0; s < DIV_LAT; s++) begin : g_stage
        logic             w_vld;
        logic             w_ovf;
        logic [QUO_W-1:0] w_rem;
        logic [QUO_W-1:0] w_lo;
        logic [QUO_W-1:0] w_quo;
        logic [QUO_W-1:0] w_den;
        logic [QUO_W:0]   w_trial;
        logic             w_ge;

        if (s == 0) begin : g_head
            assign w_vld = i_valid;
            assign w_rem = i_num[NUM_W-1:QUO_W];
            assign w_lo  = i_num[QUO_W-1:0];
            assign w_quo = '0;
            assign w_den = i_den;
            assign w_ovf = (i_num[NUM_W-1:QUO_W] >= i_den);
        end else begin : g_body
            assign w_vld = r_vld[s-1];
            assign w_rem = r_rem[s-1];
            assign w_lo  = r_lo[s-1];
            assign w_quo = r_quo[s-1];
            assign w_den = r_den[s-1];
            assign w_ovf = r_ovf[s-1];
        end

        // Shift in the next dividend bit, subtract when it fits.
        assign w_trial = {w_rem, w_lo[QUO_W-1]};
        assign w_ge    = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= w_ge ? QUO_W'(w_trial - {1'b0, w_den}) : w_trial[QUO_W-1:0];
            r_lo[s]  <= {w_lo[QUO_W-2:0], 1'b0};
            r_quo[s] <= {w_quo[QUO_W-2:0], w_ge};
            r_den[s] <= w_den;
            r_ovf[s] <= w_ovf;
        end
    end

    assign o_valid = r_vld[DIV_LAT-1];
    assign o_quo   = r_quo[DIV_LAT-1];
    assign o_ovf   = r_ovf[DIV_LAT-1];

endmodule : rgbgc_div
`default_nettype wire

/* sv/rgb_gamut_constrain_limit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_gamut_constrain_limit
// Per-pixel RGB gamut mapping in signed Q16.16: constrain pulls negative
// pixels toward gray (or to black), limit pulls over-range pixels toward
// gray, white or a clamp.
// ----------------------------------------------------------------------------
// Usage:
//   Input transaction: drive i_opcode, i_red, i_green, i_blue, i_pixel_lum and
//   raise start. A transaction is taken at every edge with start high and busy
//   low; busy never rises, so one pixel enters every clock.
//   Result: o_valid strobes for one cycle with o_red_out, o_green_out,
//   o_blue_out and o_modified. Results appear in input order. The receiver
//   cannot stall; results simply stream out.
//   Latency is set by two 32-stage pipelined dividers in series: one forms the
//   gray level from the luminance, the other scales each channel toward it
//   (three in parallel, one per channel). The remaining stages are the input
//   register, the Y-weight multipliers, gray-level fixup, channel differences,
//   the scaling multipliers and the output register.
//   Configuration: write register index/data on i_cfg_valid; o_cfg_ready is
//   always high. Write only while no pixel is in flight.
//   Reset: synchronous, active low. Clears all valid bits in the pipeline and
//   loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module rgb_gamut_constrain_limit import rgbgc_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [2:0]               i_cfg_index,
    input  wire logic [DATA_W-1:0]        i_cfg_data,
    input  wire logic                     i_opcode,
    input  wire logic signed [DATA_W-1:0] i_red,
    input  wire logic signed [DATA_W-1:0] i_green,
    input  wire logic signed [DATA_W-1:0] i_blue,
    input  wire logic signed [DATA_W-1:0] i_pixel_lum,
    output logic                          o_valid,
    output logic signed [DATA_W-1:0]      o_red_out,
    output logic signed [DATA_W-1:0]      o_green_out,
    output logic signed [DATA_W-1:0]      o_blue_out,
    output logic                          o_modified
);

    // Register indexes.
    localparam logic [2:0] REG_LUMINANCE = 3'd0;
    localparam logic [2:0] REG_COEFF_R   = 3'd1;
    localparam logic [2:0] REG_COEFF_G   = 3'd2;
    localparam logic [2:0] REG_COEFF_B   = 3'd3;
    localparam logic [2:0] REG_METHOD    = 3'd4;

    // Limit methods.
    localparam logic [1:0] METH_COMPUTED = 2'd0;
    localparam logic [1:0] METH_CLAMP    = 2'd2;

    // Opcodes.
    localparam logic OP_CONSTRAIN = 1'b0;

    // What the output stage does with a pixel.
    localparam logic [2:0] K_PASS  = 3'd0;
    localparam logic [2:0] K_BLACK = 3'd1;
    localparam logic [2:0] K_WHITE = 3'd2;
    localparam logic [2:0] K_CLAMP = 3'd3;
    localparam logic [2:0] K_CMIX  = 3'd4;
    localparam logic [2:0] K_LMIX  = 3'd5;

    localparam int LATENCY = 2 * DIV_LAT + 6;
    localparam int LUM_W   = 50;

    typedef struct packed {
        logic [2:0]               kind;
        logic                     neg;
        logic signed [DATA_W-1:0] red;
        logic signed [DATA_W-1:0] green;
        logic signed [DATA_W-1:0] blue;
    } t_pay;

    typedef struct packed {
        t_pay                     pay;
        logic signed [DATA_W-1:0] l;
        logic [2:0]               neg;
    } t_pay_mix;

    function automatic logic signed [DATA_W-1:0] f_min3(
        input logic signed [DATA_W-1:0] a, b, c
    );
        logic signed [DATA_W-1:0] ab;
        ab = (a < b) ? a : b;
        return (ab < c) ? ab : c;
    endfunction

    function automatic logic signed [DATA_W-1:0] f_max3(
        input logic signed [DATA_W-1:0] a, b, c
    );
        logic signed [DATA_W-1:0] ab;
        ab = (a > b) ? a : b;
        return (ab > c) ? ab : c;
    endfunction

    function automatic logic signed [DATA_W-1:0] f_final(
        input logic [2:0]               kind,
        input logic signed [DATA_W-1:0] c,
        input logic signed [DATA_W-1:0] l,
        input logic                     neg,
        input logic                     ovf,
        input logic [QUO_W-1:0]         q
    );
        logic        [QUO_W:0]   qe;
        logic signed [QUO_W+2:0] acc;
        logic signed [DATA_W-1:0] res;
        qe  = ovf ? {1'b1, {QUO_W{1'b0}}} : {1'b0, q};
        acc = neg ? ((QUO_W+3)'(l) - $signed({2'b00, qe}))
                  : ((QUO_W+3)'(l) + $signed({2'b00, qe}));
        unique case (kind)
            K_PASS:  res = c;
            K_BLACK: res = '0;
            K_WHITE: res = ONE_Q;
            K_CLAMP: res = (c < 0) ? '0 : ((c > ONE_Q) ? ONE_Q : c);
            K_CMIX:  res = (ovf || q[QUO_W-1]) ? S32_MAX : $signed(q);
            K_LMIX: begin
                if (acc > (QUO_W+3)'(S32_MAX)) begin
                    res = S32_MAX;
                end else if (acc < (QUO_W+3)'(S32_MIN)) begin
                    res = S32_MIN;
                end else begin
                    res = acc[DATA_W-1:0];
                end
            end
            default: res = c;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        [DATA_W-2:0] r_luminance;
    logic signed [DATA_W-1:0] r_coeff [3];
    logic        [1:0]        r_method;
    logic        [DATA_W-2:0] w_lr;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_luminance <= 31'd65536;
            r_coeff[0]  <= 32'sd13933;
            r_coeff[1]  <= 32'sd46871;
            r_coeff[2]  <= 32'sd4732;
            r_method    <= METH_COMPUTED;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_LUMINANCE: r_luminance <= i_cfg_data[DATA_W-2:0];
                REG_COEFF_R:   r_coeff[0]  <= i_cfg_data;
                REG_COEFF_G:   r_coeff[1]  <= i_cfg_data;
                REG_COEFF_B:   r_coeff[2]  <= i_cfg_data;
                REG_METHOD:    r_method    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // A zero luminance register acts as the smallest step.
    assign w_lr = (r_luminance == '0) ? (DATA_W-1)'(1) : r_luminance;

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic                     r1_valid;
    logic                     r1_op;
    logic signed [DATA_W-1:0] r1_c [3];
    logic signed [DATA_W-1:0] r1_plum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_op   <= i_opcode;
        r1_c[0] <= i_red;
        r1_c[1] <= i_green;
        r1_c[2] <= i_blue;
        r1_plum <= i_pixel_lum;
    end

    // ------------------------------------------------------------------
    // Stage 2: Y-weight products and luminance/3
    // ------------------------------------------------------------------
    logic                     r2_valid;
    logic                     r2_op;
    logic signed [DATA_W-1:0] r2_c [3];
    logic signed [DATA_W-1:0] r2_plum;
    logic signed [NUM_W-1:0]  r2_p [3];
    logic        [DATA_W-2:0] r2_lr3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_op   <= r1_op;
        r2_plum <= r1_plum;
        for (int k = 0; k < 3; k++) begin
            r2_c[k] <= r1_c[k];
            r2_p[k] <= NUM_W'(r_coeff[k]) * NUM_W'(r1_c[k]);
        end
        // Divide by three as a multiply by the rounded-up reciprocal.
        r2_lr3 <= (DATA_W-1)'((NUM_W'({1'b0, w_lr}) * 64'h0000_0000_AAAA_AAAB) >> 33);
    end

    // ------------------------------------------------------------------
    // Stage 3 (feeds the gray-level divider): classify the pixel
    // ------------------------------------------------------------------
    logic signed [LUM_W-1:0]  w_pf [3];
    logic signed [LUM_W-1:0]  w_lum;
    logic        [DATA_W-1:0] w_mag;
    logic        [NUM_W-1:0]  w_num_l;
    t_pay                     w_pay_a;
    logic                     w_any_neg;
    logic                     w_any_over;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_pf[k] = LUM_W'(r2_p[k] >>> FRAC_BITS);
        end
        w_lum = (r_method == METH_COMPUTED) ? (w_pf[0] + w_pf[1] + w_pf[2])
                                            : $signed({19'b0, r2_lr3});

        // Magnitude of the luminance, floored at the most negative word.
        if (w_lum < LUM_W'(S32_MIN)) begin
            w_mag = 32'h8000_0000;
        end else if (w_lum < 0) begin
            w_mag = DATA_W'(-w_lum);
        end else begin
            w_mag = DATA_W'(w_lum);
        end

        w_any_neg  = (r2_c[0] < 0) || (r2_c[1] < 0) || (r2_c[2] < 0);
        w_any_over = (r2_c[0] > ONE_Q) || (r2_c[1] > ONE_Q) || (r2_c[2] > ONE_Q);

        w_pay_a.red   = r2_c[0];
        w_pay_a.green = r2_c[1];
        w_pay_a.blue  = r2_c[2];
        w_pay_a.neg   = (w_lum < 0);

        if (r2_op == OP_CONSTRAIN) begin
            w_num_l = NUM_W'({1'b0, r2_plum[DATA_W-2:0]}) << FRAC_BITS;
            priority if (!w_any_neg) begin
                w_pay_a.kind = K_PASS;
            end else if (r2_plum < 0) begin
                w_pay_a.kind = K_BLACK;
            end else begin
                w_pay_a.kind = K_CMIX;
            end
        end else begin
            w_num_l = NUM_W'(w_mag) << FRAC_BITS;
            priority if (!w_any_over) begin
                w_pay_a.kind = K_PASS;
            end else if (r_method == METH_CLAMP) begin
                w_pay_a.kind = K_CLAMP;
            end else if (w_lum > $signed({19'b0, w_lr})) begin
                w_pay_a.kind = K_WHITE;
            end else begin
                w_pay_a.kind = K_LMIX;
            end
        end
    end

    // Gray level l = lum * one / luminance.
    logic             w_da_valid;
    logic [QUO_W-1:0] w_da_quo;
    logic             w_da_ovf;
    t_pay             r_dla [DIV_LAT];

    rgbgc_div u_div_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_valid),
        .i_num   (w_num_l),
        .i_den   ({1'b0, w_lr}),
        .o_valid (w_da_valid),
        .o_quo   (w_da_quo),
        .o_ovf   (w_da_ovf)
    );

    // Hold the pixel alongside the divider.
    always_ff @(posedge i_clk) begin
        r_dla[0] <= w_pay_a;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_dla[i] <= r_dla[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: signed, saturated gray level
    // ------------------------------------------------------------------
    logic                     r4_valid;
    t_pay                     r4_pay;
    logic signed [DATA_W-1:0] r4_l;
    logic signed [DATA_W-1:0] w_l;
    t_pay                     w_pay_4;

    always_comb begin
        w_pay_4 = r_dla[DIV_LAT-1];
        if (w_pay_4.kind == K_CMIX) begin
            w_l = (w_da_ovf || w_da_quo[QUO_W-1]) ? S32_MAX : $signed(w_da_quo);
        end else if (w_pay_4.neg) begin
            w_l = (w_da_ovf || (w_da_quo > 32'h8000_0000)) ? S32_MIN
                                                           : $signed(-w_da_quo);
        end else begin
            w_l = $signed(w_da_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= w_da_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_pay <= w_pay_4;
        r4_l   <= w_l;
    end

    // ------------------------------------------------------------------
    // Stage 5: distances to the gray level and the common divisor
    // ------------------------------------------------------------------
    logic                     r5_valid;
    t_pay                     r5_pay;
    logic signed [DATA_W-1:0] r5_l;
    logic        [DATA_W-1:0] r5_y;
    logic        [DATA_W-1:0] r5_x [3];
    logic        [2:0]        r5_neg;
    logic        [DATA_W-1:0] r5_d;

    logic signed [DATA_W-1:0] w_c5 [3];
    logic signed [DATA_W-1:0] w_min;
    logic signed [DATA_W-1:0] w_max;
    logic signed [DATA_W:0]   w_dl [3];
    logic        [DATA_W-1:0] w_y;
    logic        [DATA_W-1:0] w_x [3];
    logic        [2:0]        w_neg;
    logic        [DATA_W-1:0] w_d;

    always_comb begin
        w_c5[0] = r4_pay.red;
        w_c5[1] = r4_pay.green;
        w_c5[2] = r4_pay.blue;
        w_min   = f_min3(w_c5[0], w_c5[1], w_c5[2]);
        w_max   = f_max3(w_c5[0], w_c5[1], w_c5[2]);
        for (int k = 0; k < 3; k++) begin
            w_dl[k] = (DATA_W+1)'(w_c5[k]) - (DATA_W+1)'(r4_l);
        end
        if (r4_pay.kind == K_CMIX) begin
            // Scale c - min by l / (l - min).
            w_y = DATA_W'(r4_l);
            w_d = DATA_W'((DATA_W+1)'(r4_l) - (DATA_W+1)'(w_min));
            for (int k = 0; k < 3; k++) begin
                w_x[k]   = DATA_W'((DATA_W+1)'(w_c5[k]) - (DATA_W+1)'(w_min));
                w_neg[k] = 1'b0;
            end
        end else begin
            // Scale |c - l| by (one - l) / (max - l).
            w_y = DATA_W'((DATA_W+1)'(ONE_Q) - (DATA_W+1)'(r4_l));
            w_d = DATA_W'((DATA_W+1)'(w_max) - (DATA_W+1)'(r4_l));
            for (int k = 0; k < 3; k++) begin
                w_neg[k] = w_dl[k][DATA_W];
                w_x[k]   = w_neg[k] ? DATA_W'(-w_dl[k]) : DATA_W'(w_dl[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_pay <= r4_pay;
        r5_l   <= r4_l;
        r5_y   <= w_y;
        r5_neg <= w_neg;
        r5_d   <= w_d;
        for (int k = 0; k < 3; k++) begin
            r5_x[k] <= w_x[k];
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: scaling products
    // ------------------------------------------------------------------
    logic                    r6_valid;
    t_pay_mix                r6_mix;
    logic       [NUM_W-1:0]  r6_n [3];
    logic       [DATA_W-1:0] r6_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_mix.pay <= r5_pay;
        r6_mix.l   <= r5_l;
        r6_mix.neg <= r5_neg;
        r6_d       <= r5_d;
        for (int k = 0; k < 3; k++) begin
            r6_n[k] <= NUM_W'(r5_y) * NUM_W'(r5_x[k]);
        end
    end

    // Per-channel dividers.
    logic             w_db_valid [3];
    logic [QUO_W-1:0] w_db_quo   [3];
    logic             w_db_ovf   [3];
    t_pay_mix         r_dlb [DIV_LAT];

    for (genvar k = 0; k < 3; k++) begin : g_chan_div
        rgbgc_div u_div_q (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r6_valid),
            .i_num   (r6_n[k]),
            .i_den   (r6_d),
            .o_valid (w_db_valid[k]),
            .o_quo   (w_db_quo[k]),
            .o_ovf   (w_db_ovf[k])
        );
    end

    always_ff @(posedge i_clk) begin
        r_dlb[0] <= r6_mix;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_dlb[i] <= r_dlb[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Output register: pick the result per kind and saturate
    // ------------------------------------------------------------------
    t_pay_mix w_mix_o;

    assign w_mix_o = r_dlb[DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_db_valid[0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_red_out   <= f_final(w_mix_o.pay.kind, w_mix_o.pay.red, w_mix_o.l,
                               w_mix_o.neg[0], w_db_ovf[0], w_db_quo[0]);
        o_green_out <= f_final(w_mix_o.pay.kind, w_mix_o.pay.green, w_mix_o.l,
                               w_mix_o.neg[1], w_db_ovf[1], w_db_quo[1]);
        o_blue_out  <= f_final(w_mix_o.pay.kind, w_mix_o.pay.blue, w_mix_o.l,
                               w_mix_o.neg[2], w_db_ovf[2], w_db_quo[2]);
        o_modified  <= (w_mix_o.pay.kind != K_PASS);
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every result strobe traces back to an accepted input transaction.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching input transaction");

    // The channel divisor of a mixing pixel is never zero.
    a_den_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r6_valid && (r6_mix.pay.kind == K_CMIX || r6_mix.pay.kind == K_LMIX))
            |-> (r6_d != '0))
        else $error("zero divisor in channel scaling");

    // In limit mixing the gray level never exceeds one.
    a_gray_le_one : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r4_valid && r4_pay.kind == K_LMIX) |-> (r4_l <= ONE_Q))
        else $error("limit gray level above one");

endmodule : rgb_gamut_constrain_limit
`default_nettype wire
